### rtl/core/bdit_pkg.sv
// shared types and constants for the block distribution index translator
`default_nettype none
package bdit_pkg;

   localparam int MAX_DIMS   = 4;
   localparam int INDEX_BITS = 16;
   localparam int VALUE_BITS = 18;
   localparam int WORK_BITS  = 20;
   localparam int DVD_BITS   = 18;
   localparam int DSR_BITS   = 16;
   localparam int REM_STAGES = DVD_BITS / 2;

   typedef enum logic [2:0] {
      OP_LOOP_START = 3'd0,
      OP_LOOP_STOP  = 3'd1,
      OP_G2L        = 3'd2,
      OP_G2L_GHOST  = 3'd3,
      OP_L2G        = 3'd4,
      OP_L2G_GHOST  = 3'd5
   } op_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_BAD_DIM   = 2'd1,
      ST_ZERO_STEP = 2'd2,
      ST_NOT_OWNED = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      CSR_NUM_DIMS     = 3'd0,
      CSR_ACTIVE       = 3'd1,
      CSR_LOW_BOUNDS   = 3'd2,
      CSR_HIGH_BOUNDS  = 3'd3,
      CSR_GHOST_COUNTS = 3'd4,
      CSR_GLOBAL_SIZES = 3'd5
   } csr_type;

   typedef struct packed {
      logic signed [WORK_BITS-1:0] pre;
      logic                        neg;
      logic [1:0]                  status;
      logic [DSR_BITS-1:0]         rem;
      logic [DVD_BITS-1:0]         dvd;
      logic [DSR_BITS-1:0]         dsr;
   } pipe_type;

endpackage
`default_nettype wire

### rtl/core/bdit_decode.sv
// first stage: checks, bound lookup and base value ahead of the stride modulo
`default_nettype none
module bdit_decode (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         adv,
   input  wire logic                         in_valid,
   input  wire logic [2:0]                   op,
   input  wire logic [1:0]                   dim,
   input  wire logic signed [15:0]           index,
   input  wire logic signed [15:0]           stride,
   input  wire logic [2:0]                   num_dims,
   input  wire logic                         active,
   input  wire logic [63:0]                  low_bounds,
   input  wire logic [63:0]                  high_bounds,
   input  wire logic [31:0]                  ghost_counts,
   input  wire logic [63:0]                  global_sizes,
   output logic                              valid_ff,
   output bdit_pkg::pipe_type                pipe_ff
);
   import bdit_pkg::*;

   logic signed [WORK_BITS-1:0] idx, stp, lo, hi, g, gsz, size, ii, r, minus1;
   logic [15:0] lo_raw, hi_raw, gs_raw;
   pipe_type pipe_in;
   logic valid_in;

   assign valid_in = in_valid;

   always_comb begin
      lo_raw = low_bounds[16*dim +: 16];
      hi_raw = high_bounds[16*dim +: 16];
      gs_raw = global_sizes[16*dim +: 16];
      idx    = WORK_BITS'(index);
      stp    = WORK_BITS'(stride);
      lo     = WORK_BITS'($signed(lo_raw));
      hi     = WORK_BITS'($signed(hi_raw));
      g      = WORK_BITS'({1'b0, ghost_counts[8*dim +: 8]});
      gsz    = WORK_BITS'({1'b0, gs_raw});
      size   = hi - lo + WORK_BITS'(1);
      ii     = idx - g;
      r      = lo + ii;
      minus1 = -WORK_BITS'(1);

      pipe_in.pre    = minus1;
      pipe_in.neg    = 1'b0;
      pipe_in.status = ST_NOT_OWNED;
      pipe_in.rem    = '0;
      pipe_in.dvd    = '0;
      pipe_in.dsr    = DSR_BITS'(1);

      if (op > OP_L2G_GHOST) begin
         pipe_in.status = ST_NOT_OWNED;
      end else if ({1'b0, dim} >= num_dims) begin
         pipe_in.status = ST_BAD_DIM;
      end else if ((op == OP_LOOP_START || op == OP_LOOP_STOP) && stride == 16'sd0) begin
         pipe_in.status = ST_ZERO_STEP;
      end else if (!active) begin
         if ((op == OP_LOOP_START && stride > 0) || (op == OP_LOOP_STOP && stride < 0)) begin
            pipe_in.pre    = g;
            pipe_in.status = ST_OK;
         end
      end else begin
         case (op_type'(op))
            OP_LOOP_START: begin
               pipe_in.status = ST_OK;
               pipe_in.pre    = idx - lo + g;
               if (stride > 0 && idx < lo) begin
                  pipe_in.pre = stp - WORK_BITS'(1) + g;
                  pipe_in.neg = 1'b1;
                  pipe_in.dvd = DVD_BITS'(lo - idx - WORK_BITS'(1));
                  pipe_in.dsr = DSR_BITS'(stp);
               end else if (stride < 0 && idx > hi) begin
                  pipe_in.pre = hi - lo + stp + WORK_BITS'(1) + g;
                  pipe_in.dvd = DVD_BITS'(idx - hi - WORK_BITS'(1));
                  pipe_in.dsr = DSR_BITS'(-stp);
               end
            end
            OP_LOOP_STOP: begin
               pipe_in.status = ST_OK;
               if (stride > 0) begin
                  pipe_in.pre = ((idx < hi) ? idx : hi) - lo + g;
               end else begin
                  pipe_in.pre = ((idx > lo) ? idx : lo) - lo + g;
               end
            end
            OP_G2L: begin
               if (!(idx < lo || idx > hi)) begin
                  pipe_in.pre    = idx - lo + g;
                  pipe_in.status = ST_OK;
               end
            end
            OP_G2L_GHOST: begin
               if (!(idx < lo - g || idx > hi + g)) begin
                  pipe_in.pre    = idx - lo + g;
                  pipe_in.status = ST_OK;
               end
            end
            OP_L2G: begin
               if (!(ii < 0 || ii >= size)) begin
                  pipe_in.pre    = r;
                  pipe_in.status = ST_OK;
               end
            end
            OP_L2G_GHOST: begin
               if (!(ii < -g || ii >= size + g || r < 0 || r >= gsz)) begin
                  pipe_in.pre    = r;
                  pipe_in.status = ST_OK;
               end
            end
            default: begin
               pipe_in.status = ST_NOT_OWNED;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pipe_ff <= pipe_in;
      end
   end

endmodule
`default_nettype wire

### rtl/core/bdit_rem_stage.sv
// one stage of the stride remainder: two restoring steps
`default_nettype none
module bdit_rem_stage (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                adv,
   input  wire logic                in_valid,
   input  wire bdit_pkg::pipe_type  pipe,
   output logic                     valid_ff,
   output bdit_pkg::pipe_type       pipe_ff
);
   import bdit_pkg::*;

   logic [DSR_BITS:0] t0, t1;
   logic [DSR_BITS-1:0] r0;
   pipe_type pipe_in;
   logic valid_in;

   assign valid_in = in_valid;

   always_comb begin
      t0 = {pipe.rem, pipe.dvd[DVD_BITS-1]};
      if (t0 >= {1'b0, pipe.dsr}) begin
         t0 = t0 - {1'b0, pipe.dsr};
      end
      r0 = t0[DSR_BITS-1:0];
      t1 = {r0, pipe.dvd[DVD_BITS-2]};
      if (t1 >= {1'b0, pipe.dsr}) begin
         t1 = t1 - {1'b0, pipe.dsr};
      end
      pipe_in     = pipe;
      pipe_in.rem = t1[DSR_BITS-1:0];
      pipe_in.dvd = {pipe.dvd[DVD_BITS-3:0], 2'b00};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pipe_ff <= pipe_in;
      end
   end

endmodule
`default_nettype wire

### rtl/core/block_dist_index_translate.sv
// top level of the block distribution index translator
// a request passes the decode register, the stride remainder stages and the response register
// throughput: one transaction per cycle while the response is not stalled; the 9-stage stride remainder sets the depth
// the whole pipeline holds while the response register is full and stalled
// synchronous reset clears valid bits and loads register defaults (1 dim, active)
`default_nettype none
module block_dist_index_translate (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [2:0]         req_op,
   input  wire logic [1:0]         req_dim,
   input  wire logic signed [15:0] req_index,
   input  wire logic signed [15:0] req_stride,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic signed [17:0]      rsp_value,
   output logic [1:0]              rsp_status,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [2:0]         csr_index,
   input  wire logic [63:0]        csr_data
);
   import bdit_pkg::*;

   logic [2:0]  num_dims_ff;
   logic        active_ff;
   logic [63:0] low_bounds_ff, high_bounds_ff, global_sizes_ff;
   logic [31:0] ghost_counts_ff;

   logic adv;
   logic     valid_pipe [REM_STAGES+1];
   pipe_type pipe_pipe  [REM_STAGES+1];

   logic                         rsp_valid_ff;
   logic signed [VALUE_BITS-1:0] rsp_value_ff, rsp_value_in;
   logic [1:0]                   rsp_status_ff;
   logic signed [WORK_BITS-1:0]  rem_ext;

   assign csr_ready = 1'b1;
   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         num_dims_ff     <= 3'd1;
         active_ff       <= 1'b1;
         low_bounds_ff   <= '0;
         high_bounds_ff  <= '0;
         ghost_counts_ff <= '0;
         global_sizes_ff <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_NUM_DIMS:     num_dims_ff     <= csr_data[2:0];
            CSR_ACTIVE:       active_ff       <= csr_data[0];
            CSR_LOW_BOUNDS:   low_bounds_ff   <= csr_data;
            CSR_HIGH_BOUNDS:  high_bounds_ff  <= csr_data;
            CSR_GHOST_COUNTS: ghost_counts_ff <= csr_data[31:0];
            CSR_GLOBAL_SIZES: global_sizes_ff <= csr_data;
            default: begin
            end
         endcase
      end
   end

   bdit_decode u_decode (
      .clock        (clock),
      .reset        (reset),
      .adv          (adv),
      .in_valid     (req_valid),
      .op           (req_op),
      .dim          (req_dim),
      .index        (req_index),
      .stride       (req_stride),
      .num_dims     (num_dims_ff),
      .active       (active_ff),
      .low_bounds   (low_bounds_ff),
      .high_bounds  (high_bounds_ff),
      .ghost_counts (ghost_counts_ff),
      .global_sizes (global_sizes_ff),
      .valid_ff     (valid_pipe[0]),
      .pipe_ff      (pipe_pipe[0])
   );

   for (genvar s = 0; s < REM_STAGES; s++) begin : g_rem
      bdit_rem_stage u_rem (
         .clock    (clock),
         .reset    (reset),
         .adv      (adv),
         .in_valid (valid_pipe[s]),
         .pipe     (pipe_pipe[s]),
         .valid_ff (valid_pipe[s+1]),
         .pipe_ff  (pipe_pipe[s+1])
      );
   end

   // apply the aligned remainder to the base value
   always_comb begin
      rem_ext = WORK_BITS'({1'b0, pipe_pipe[REM_STAGES].rem});
      if (pipe_pipe[REM_STAGES].neg) begin
         rsp_value_in = VALUE_BITS'(pipe_pipe[REM_STAGES].pre - rem_ext);
      end else begin
         rsp_value_in = VALUE_BITS'(pipe_pipe[REM_STAGES].pre + rem_ext);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= valid_pipe[REM_STAGES];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_value_ff  <= rsp_value_in;
         rsp_status_ff <= pipe_pipe[REM_STAGES].status;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_value  = rsp_value_ff;
   assign rsp_status = rsp_status_ff;

endmodule
`default_nettype wire

### tb/block_dist_index_translate_test.sv
// self-checking testbench for the block distribution index translator
`timescale 1ns / 100ps
`default_nettype none
module block_dist_index_translate_test;
   import bdit_pkg::*;

   typedef struct {
      logic [2:0]         op;
      logic [1:0]         dim;
      logic signed [15:0] index;
      logic signed [15:0] stride;
   } xlat_req;

   typedef struct {
      logic signed [17:0] value;
      logic [1:0]         status;
   } xlat_rsp;

   typedef struct {
      xlat_req req;
      logic    known;
      xlat_rsp rsp;
   } dir_row;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic [2:0]         req_op;
   logic [1:0]         req_dim;
   logic signed [15:0] req_index;
   logic signed [15:0] req_stride;
   logic               rsp_valid;
   logic               rsp_stall;
   logic signed [17:0] rsp_value;
   logic [1:0]         rsp_status;
   logic               csr_valid;
   logic               csr_ready;
   logic [2:0]         csr_index;
   logic [63:0]        csr_data;

   block_dist_index_translate dut (.*);

   // shadow copy of the register file
   logic [2:0]  cfg_num_dims;
   logic        cfg_active;
   logic [63:0] cfg_low;
   logic [63:0] cfg_high;
   logic [31:0] cfg_ghost;
   logic [63:0] cfg_gsize;

   xlat_rsp     pending_q[$];
   int          fail_count;
   int          table_fails;
   int          rsp_count;
   int          cycle_count;
   bit          quiet_tail;
   bit          rsp_noise;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 400000) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("Verification failed");
         $finish;
      end
   end

   function automatic xlat_rsp translate(xlat_req r);
      xlat_rsp o;
      longint lo, hi, g, gs, sz, rv, i, idx, st;
      logic [1:0] d;
      d = r.dim;
      idx = r.index;
      st = r.stride;
      lo = $signed(cfg_low[d*16 +: 16]);
      hi = $signed(cfg_high[d*16 +: 16]);
      g = cfg_ghost[d*8 +: 8];
      gs = cfg_gsize[d*16 +: 16];
      sz = cfg_active ? hi - lo + 1 : 0;
      o.value = -1;
      o.status = ST_NOT_OWNED;
      if (r.op > OP_L2G_GHOST) return o;
      if (d >= cfg_num_dims) begin
         o.status = ST_BAD_DIM;
         return o;
      end
      if (r.op <= OP_LOOP_STOP && st == 0) begin
         o.status = ST_ZERO_STEP;
         return o;
      end
      if (!cfg_active) begin
         if ((r.op == OP_LOOP_START && st > 0) || (r.op == OP_LOOP_STOP && st < 0)) begin
            o.value = g;
            o.status = ST_OK;
         end
         return o;
      end
      case (r.op)
         OP_LOOP_START: begin
            rv = idx;
            if (st > 0 && idx < lo) rv = lo + st - 1 - (lo - idx - 1) % st;
            else if (st < 0 && idx > hi) rv = hi + st + 1 + (idx - hi - 1) % (-st);
            o.value = rv - lo + g;
            o.status = ST_OK;
         end
         OP_LOOP_STOP: begin
            if (st > 0) rv = idx < hi ? idx : hi;
            else rv = idx > lo ? idx : lo;
            o.value = rv - lo + g;
            o.status = ST_OK;
         end
         OP_G2L: if (!(idx < lo || idx > hi)) begin
            o.value = idx - lo + g;
            o.status = ST_OK;
         end
         OP_G2L_GHOST: if (!(idx < lo - g || idx > hi + g)) begin
            o.value = idx - lo + g;
            o.status = ST_OK;
         end
         OP_L2G: begin
            i = idx - g;
            if (!(i < 0 || i >= sz)) begin
               o.value = lo + i;
               o.status = ST_OK;
            end
         end
         default: begin
            i = idx - g;
            rv = lo + i;
            if (!(i < -g || i >= sz + g) && !(rv < 0 || rv >= gs)) begin
               o.value = rv;
               o.status = ST_OK;
            end
         end
      endcase
      return o;
   endfunction

   task automatic idle_gap();
      int n;
      if (!quiet_tail && $urandom_range(0, 5) == 0) begin
         n = $urandom_range(1, 12);
         req_valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   // valid stays high after acceptance; the next issue or drain settles it
   task automatic issue(xlat_req r);
      idle_gap();
      req_valid <= 1'b1;
      req_op <= r.op;
      req_dim <= r.dim;
      req_index <= r.index;
      req_stride <= r.stride;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_q.push_back(translate(r));
   endtask

   task automatic write_csr(csr_type idx, logic [63:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
      case (idx)
         CSR_NUM_DIMS:     cfg_num_dims = data[2:0];
         CSR_ACTIVE:       cfg_active = data[0];
         CSR_LOW_BOUNDS:   cfg_low = data;
         CSR_HIGH_BOUNDS:  cfg_high = data;
         CSR_GHOST_COUNTS: cfg_ghost = data[31:0];
         default:          cfg_gsize = data;
      endcase
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_q.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
   endtask

   task automatic check_row(dir_row row, int n);
      if (row.known && pending_q[$] != row.rsp) begin
         $display("%0t: table row %0d expected value %0d status %0d, got %0d status %0d",
                  $time, n, row.rsp.value, row.rsp.status, pending_q[$].value,
                  pending_q[$].status);
         table_fails++;
      end
   endtask

   // receiver: random stall bursts, checks each transaction in order
   always @(posedge clock) begin
      xlat_rsp want;
      if (!reset && rsp_valid && !rsp_stall) begin
         rsp_count <= rsp_count + 1;
         if (pending_q.size() == 0) begin
            $display("%0t: unexpected response value %0d status %0d", $time,
                     rsp_value, rsp_status);
            fail_count <= fail_count + 1;
         end else begin
            want = pending_q.pop_front();
            if (want.value !== rsp_value || want.status !== rsp_status) begin
               $display("%0t: mismatch expected value %0d status %0d, got %0d status %0d",
                        $time, want.value, want.status, rsp_value, rsp_status);
               fail_count <= fail_count + 1;
            end
         end
      end
   end

   initial begin : stall_gen
      int n;
      rsp_stall = 1'b0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (!quiet_tail && rsp_noise && $urandom_range(0, 5) == 0) begin
            n = $urandom_range(1, 12);
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
         end
         rsp_stall <= 1'b0;
      end
   end

   function automatic xlat_req rand_req(bit legal);
      xlat_req r;
      logic [1:0] d;
      int sel;
      d = 2'($urandom_range(0, 3));
      sel = $urandom_range(0, 3);
      r.op = legal ? 3'($urandom_range(0, 5)) : 3'($urandom_range(0, 7));
      r.dim = legal && cfg_num_dims != 0 ? 2'($urandom_range(0, cfg_num_dims > 4 ? 3 :
                                                             cfg_num_dims - 1)) : d;
      // aim indices near the owned range most of the time
      if (sel == 0) r.index = 16'($urandom);
      else r.index = $signed(cfg_low[r.dim*16 +: 16]) + $signed(16'($urandom_range(0, 80)))
                     - 16'sd40;
      r.stride = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 14)) - 16'sd7;
      return r;
   endfunction

   initial begin : main
      dir_row rows[$];
      dir_row row;
      xlat_req r;
      int k;
      logic [63:0] lo, hi;
      fail_count = 0;
      table_fails = 0;
      rsp_count = 0;
      cycle_count = 0;
      quiet_tail = 0;
      rsp_noise = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_op = '0;
      req_dim = '0;
      req_index = '0;
      req_stride = '0;
      csr_valid = 1'b0;
      csr_index = CSR_NUM_DIMS;
      csr_data = '0;
      cfg_num_dims = 3'd1;
      cfg_active = 1'b1;
      cfg_low = '0;
      cfg_high = '0;
      cfg_ghost = '0;
      cfg_gsize = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // after reset: dim 0 owns only global index 0
      rows.push_back('{'{OP_G2L, 2'd0, 16'sd0, 16'sd1}, 1, '{18'sd0, ST_OK}});
      rows.push_back('{'{OP_G2L, 2'd0, 16'sd1, 16'sd1}, 1, '{-18'sd1, ST_NOT_OWNED}});
      rows.push_back('{'{OP_G2L, 2'd1, 16'sd0, 16'sd1}, 1, '{-18'sd1, ST_BAD_DIM}});
      rows.push_back('{'{3'd6, 2'd0, 16'sd0, 16'sd1}, 1, '{-18'sd1, ST_NOT_OWNED}});
      rows.push_back('{'{3'd7, 2'd3, 16'sd0, 16'sd1}, 1, '{-18'sd1, ST_NOT_OWNED}});
      rows.push_back('{'{OP_LOOP_START, 2'd0, 16'sd5, 16'sd0}, 1, '{-18'sd1, ST_ZERO_STEP}});
      rows.push_back('{'{OP_LOOP_STOP, 2'd0, 16'sd5, 16'sd0}, 1, '{-18'sd1, ST_ZERO_STEP}});
      rows.push_back('{'{OP_L2G, 2'd0, 16'sd0, 16'sd0}, 1, '{18'sd0, ST_OK}});
      rows.push_back('{'{OP_L2G_GHOST, 2'd0, 16'sd0, 16'sd0}, 1, '{-18'sd1, ST_NOT_OWNED}});
      foreach (rows[n]) begin
         issue(rows[n].req);
         check_row(rows[n], n);
      end
      drain();

      // extremes: four dims, wide bounds and ghosts
      write_csr(CSR_NUM_DIMS, 64'd4);
      write_csr(CSR_LOW_BOUNDS, {16'sh8000, 16'sd100, 16'sd10, 16'sh7ff0});
      write_csr(CSR_HIGH_BOUNDS, {16'sh7fff, 16'sd50, 16'sd200, 16'sh7fff});
      write_csr(CSR_GHOST_COUNTS, 32'hff_03_02_ff);
      write_csr(CSR_GLOBAL_SIZES, 64'hffff_0080_00c8_ffff);
      rows.delete();
      rows.push_back('{'{OP_LOOP_START, 2'd1, -16'sd33, 16'sd7}, 0, '{0, 0}});
      rows.push_back('{'{OP_LOOP_START, 2'd1, 16'sd300, -16'sd9}, 0, '{0, 0}});
      rows.push_back('{'{OP_LOOP_START, 2'd3, 16'sh8000, 16'sh7fff}, 0, '{0, 0}});
      rows.push_back('{'{OP_LOOP_START, 2'd3, 16'sh7fff, 16'sh8000}, 0, '{0, 0}});
      rows.push_back('{'{OP_LOOP_STOP, 2'd1, 16'sd500, 16'sd3}, 0, '{0, 0}});
      rows.push_back('{'{OP_LOOP_STOP, 2'd1, -16'sd500, -16'sd3}, 0, '{0, 0}});
      rows.push_back('{'{OP_G2L_GHOST, 2'd0, 16'sh7fff, 16'sd0}, 0, '{0, 0}});
      rows.push_back('{'{OP_G2L, 2'd2, 16'sd60, 16'sd0}, 0, '{0, 0}});
      rows.push_back('{'{OP_L2G, 2'd2, 16'sd3, 16'sd0}, 0, '{0, 0}});
      rows.push_back('{'{OP_L2G_GHOST, 2'd3, 16'sh7fff, 16'sd0}, 0, '{0, 0}});
      rows.push_back('{'{OP_L2G_GHOST, 2'd1, 16'sd0, 16'sd0}, 0, '{0, 0}});
      rows.push_back('{'{OP_G2L_GHOST, 2'd3, 16'sh8000, 16'sd0}, 0, '{0, 0}});
      foreach (rows[n]) issue(rows[n].req);
      drain();
      write_csr(CSR_ACTIVE, 64'd0);
      rows.delete();
      rows.push_back('{'{OP_LOOP_START, 2'd0, 16'sd0, 16'sd1}, 1, '{18'sd255, ST_OK}});
      rows.push_back('{'{OP_LOOP_START, 2'd0, 16'sd0, -16'sd1}, 1, '{-18'sd1, ST_NOT_OWNED}});
      rows.push_back('{'{OP_LOOP_STOP, 2'd1, 16'sd0, -16'sd1}, 1, '{18'sd2, ST_OK}});
      rows.push_back('{'{OP_G2L, 2'd0, 16'sd0, 16'sd1}, 1, '{-18'sd1, ST_NOT_OWNED}});
      foreach (rows[n]) begin
         issue(rows[n].req);
         check_row(rows[n], n);
      end
      drain();
      write_csr(CSR_NUM_DIMS, 64'd0);
      r = '{OP_G2L, 2'd0, 16'sd0, 16'sd0};
      issue(r);
      drain();

      // random phases with fresh settings
      rsp_noise = 1;
      for (int ph = 0; ph < 12; ph++) begin
         write_csr(CSR_NUM_DIMS, ph == 0 ? 64'd7 : 64'($urandom_range(0, 5)));
         write_csr(CSR_ACTIVE, 64'($urandom_range(0, 5) != 0));
         for (int d = 0; d < 4; d++) begin
            k = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 400) - 100;
            lo[d*16 +: 16] = 16'(k);
            hi[d*16 +: 16] = $urandom_range(0, 7) == 0 ? 16'($urandom)
                             : 16'(k + $urandom_range(0, 60) - 5);
         end
         write_csr(CSR_LOW_BOUNDS, lo);
         write_csr(CSR_HIGH_BOUNDS, hi);
         write_csr(CSR_GHOST_COUNTS, ph == 1 ? 64'hffffffff : 64'($urandom & 32'h0f0f_1f07));
         write_csr(CSR_GLOBAL_SIZES, {$urandom, $urandom});
         if (ph == 11) quiet_tail = 1;
         for (int n = 0; n < 120; n++) issue(rand_req($urandom_range(0, 9) != 0));
         drain();
      end

      $display("covered %0d responses over 6 ops, 4 dims, inactive and bad-dim settings",
               rsp_count);
      if (fail_count == 0 && table_fails == 0) begin
         $display("Verification passed");
      end else begin
         $display("%0d mismatches", fail_count + table_fails);
         $display("Verification failed");
      end
      $finish;
   end
endmodule
`default_nettype wire
